// ===== src/puc_pkg.sv =====
// Shared types, constants and helpers for the planar row to chunky unpacker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package puc_pkg;

    localparam int GROUP_W      = 6;   // width of group_index on the result port
    localparam int GROUPS_CFG_W = 7;   // width of groups_per_row register
    localparam int BYTE_W       = 8;
    localparam int PIX_W        = 4;
    localparam int NUM_PIX      = 8;
    localparam int NUM_STORED   = 3;   // blue, green, red kept in the store
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int MAX_GROUPS_DEF = 64;

    // Register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_GROUPS_PER_ROW = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BINARY_MODE    = CFG_INDEX_W'(1);

    // Plane codes within a planar row
    localparam logic [1:0] PLANE_BLUE  = 2'd0;
    localparam logic [1:0] PLANE_GREEN = 2'd1;
    localparam logic [1:0] PLANE_RED   = 2'd2;
    localparam logic [1:0] PLANE_INTEN = 2'd3;

    // One issued byte operation
    typedef struct packed {
        logic               result;   // byte completes a group
        logic               wr_en;    // byte goes into the plane store
        logic               rd_en;    // store entry is fetched for assembly
        logic [1:0]         plane;
        logic [GROUP_W-1:0] group;
        logic               row_end;
        logic               binary;
        logic [BYTE_W-1:0]  data;
    } puc_op_t;

    // Group waiting on its store read
    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic               row_end;
        logic               binary;
        logic [BYTE_W-1:0]  data;
    } puc_grp_t;

    typedef logic [NUM_STORED-1:0][BYTE_W-1:0] puc_planes_t;

    // Effective group count: 0 acts as 1, values above the limit clamp
    function automatic logic [GROUPS_CFG_W-1:0] eff_groups(
        input logic [GROUPS_CFG_W-1:0] g,
        input logic [GROUPS_CFG_W-1:0] max_g
    );
        logic [GROUPS_CFG_W-1:0] r;
        r = g;
        if (r == '0) r = GROUPS_CFG_W'(1);
        if (r > max_g) r = max_g;
        return r;
    endfunction

endpackage

// ===== src/planar_row_to_chunky_unpacker_core.sv =====
// Top level of the planar row to chunky unpacker.
// Depends on puc_pkg, puc_sequencer, puc_plane_ram, puc_out_stage.
`timescale 1ns / 1ps

// Takes an image one byte per beat and emits eight-pixel groups. Planar mode
// (binary_mode = 0): each row is four planes of groups_per_row bytes (blue,
// green, red, intensity); the first three planes go into a per-group store
// and each intensity byte yields a group of 4-bit palette indices, pix0 from
// bit 7. Binary mode: every byte yields a group of 1-bit pixels. m_row_end
// marks the last group of a row. Throughput is one byte per clock with no
// bubbles while m_ready is high: a planar byte costs exactly one store access
// (a lane write or an entry read) and a binary byte costs none, so the store
// never sees two accesses in one beat. An accepted group passes the read stage
// (store read), then the result register. The store needs no clear after
// reset, since an entry is always written earlier in the row it is read in.
// Config writes must come only while the block is idle; it does not enforce
// this (cfg_ready is tied high). Any write to a known register restarts the row.

module planar_row_to_chunky_unpacker_core import puc_pkg::*; #(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // byte input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_data_byte,
    // group output
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PIX_W-1:0]       m_pix0,
    output logic [PIX_W-1:0]       m_pix1,
    output logic [PIX_W-1:0]       m_pix2,
    output logic [PIX_W-1:0]       m_pix3,
    output logic [PIX_W-1:0]       m_pix4,
    output logic [PIX_W-1:0]       m_pix5,
    output logic [PIX_W-1:0]       m_pix6,
    output logic [PIX_W-1:0]       m_pix7,
    output logic [GROUP_W-1:0]     m_group_index,
    output logic                   m_row_end
);

    localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    puc_op_t      op;
    puc_planes_t  rd_planes;
    logic         accept;
    logic         out_free;
    logic [PIX_W-1:0] pix [NUM_PIX];

    // read stage: holds a finished group while its store entry is fetched
    logic         s1_valid_reg, s1_valid_next;
    puc_grp_t     s1_reg;

    assign s_ready = !s1_valid_reg || out_free;
    assign accept  = s_valid && s_ready;

    puc_sequencer #(
        .MAX_GROUPS (MAX_GROUPS),
        .AW         (AW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (s_data_byte),
        .op        (op)
    );

    // write and read never hit in the same beat, so both ports share the group
    puc_plane_ram #(
        .MAX_GROUPS (MAX_GROUPS),
        .AW         (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (op.wr_en),
        .wr_lane (op.plane),
        .wr_addr (op.group[AW-1:0]),
        .wr_data (op.data),
        .rd_en   (op.rd_en),
        .rd_addr (op.group[AW-1:0]),
        .rd_data (rd_planes)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept && op.result) begin
            s1_valid_next = 1'b1;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && op.result) begin
            s1_reg.group   <= op.group;
            s1_reg.row_end <= op.row_end;
            s1_reg.binary  <= op.binary;
            s1_reg.data    <= op.data;
        end
    end

    puc_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (s1_valid_reg && out_free),
        .grp           (s1_reg),
        .planes        (rd_planes),
        .free          (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pix         (pix),
        .m_group_index (m_group_index),
        .m_row_end     (m_row_end)
    );

    assign m_pix0 = pix[0];
    assign m_pix1 = pix[1];
    assign m_pix2 = pix[2];
    assign m_pix3 = pix[3];
    assign m_pix4 = pix[4];
    assign m_pix5 = pix[5];
    assign m_pix6 = pix[6];
    assign m_pix7 = pix[7];

endmodule

// ===== src/puc_plane_ram.sv =====
// Plane store: one entry per group, three byte lanes (blue, green, red).
// Byte-lane writes, registered read. Depends on puc_pkg.
`timescale 1ns / 1ps

module puc_plane_ram import puc_pkg::*; #(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF,
    parameter int AW         = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [1:0]        wr_lane,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output puc_planes_t       rd_data
);

    puc_planes_t mem [MAX_GROUPS];
    puc_planes_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr][wr_lane] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/puc_sequencer.sv =====
// Config registers and row position tracking (plane and group counters).
// Issues at most one store write or one store read per accepted beat. Depends on puc_pkg.
`timescale 1ns / 1ps

module puc_sequencer import puc_pkg::*; #(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF,
    parameter int AW         = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   accept,
    input  logic [BYTE_W-1:0]      data_byte,
    output puc_op_t                op
);

    localparam logic [GROUPS_CFG_W-1:0] MAX_G = GROUPS_CFG_W'(MAX_GROUPS);

    logic [GROUPS_CFG_W-1:0] groups_reg, groups_next;
    logic                    binary_reg, binary_next;
    logic [1:0]              plane_reg, plane_next;
    logic [AW-1:0]           group_reg, group_next;
    logic [GROUPS_CFG_W-1:0] eff_g;
    logic                    last_group;

    assign cfg_ready  = 1'b1;
    assign eff_g      = eff_groups(groups_reg, MAX_G);
    assign last_group = (GROUPS_CFG_W'(group_reg) + GROUPS_CFG_W'(1)) == eff_g;

    always_comb begin
        op.result  = binary_reg || (plane_reg == PLANE_INTEN);
        op.wr_en   = accept && !op.result;
        op.rd_en   = accept && !binary_reg && (plane_reg == PLANE_INTEN);
        op.plane   = plane_reg;
        op.group   = GROUP_W'(group_reg);
        op.row_end = op.result && last_group;
        op.binary  = binary_reg;
        op.data    = data_byte;
    end

    always_comb begin
        groups_next = groups_reg;
        binary_next = binary_reg;
        plane_next  = plane_reg;
        group_next  = group_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_GROUPS_PER_ROW: begin
                    groups_next = cfg_data[GROUPS_CFG_W-1:0];
                    plane_next  = PLANE_BLUE;
                    group_next  = '0;
                end
                REG_BINARY_MODE: begin
                    binary_next = cfg_data[0];
                    plane_next  = PLANE_BLUE;
                    group_next  = '0;
                end
                default: ;
            endcase
        end else if (accept) begin
            if (last_group) begin
                group_next = '0;
                // planar: step to next plane, wrapping after intensity
                plane_next = binary_reg ? PLANE_BLUE : plane_reg + 2'd1;
            end else begin
                group_next = group_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            groups_reg <= GROUPS_CFG_W'(1);
            binary_reg <= 1'b0;
            plane_reg  <= PLANE_BLUE;
            group_reg  <= '0;
        end else begin
            groups_reg <= groups_next;
            binary_reg <= binary_next;
            plane_reg  <= plane_next;
            group_reg  <= group_next;
        end
    end

endmodule

// ===== src/puc_out_stage.sv =====
// Pixel assembly from store lanes plus intensity byte, and the result register.
// Depends on puc_pkg.
`timescale 1ns / 1ps

module puc_out_stage import puc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  puc_grp_t           grp,
    input  puc_planes_t        planes,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIX_W-1:0]   m_pix [NUM_PIX],
    output logic [GROUP_W-1:0] m_group_index,
    output logic               m_row_end
);

    logic                 valid_reg, valid_next;
    logic [PIX_W-1:0]     pix_reg [NUM_PIX];
    logic [PIX_W-1:0]     pix_next [NUM_PIX];
    logic [GROUP_W-1:0]   group_reg;
    logic                 row_end_reg;

    assign free = !valid_reg || m_ready;

    // pixel k takes bit 7-k of every plane; binary mode uses the byte alone
    always_comb begin
        for (int k = 0; k < NUM_PIX; k++) begin
            if (grp.binary) begin
                pix_next[k] = {3'b000, grp.data[NUM_PIX-1-k]};
            end else begin
                pix_next[k] = {grp.data[NUM_PIX-1-k], planes[2][NUM_PIX-1-k],
                               planes[1][NUM_PIX-1-k], planes[0][NUM_PIX-1-k]};
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pix_reg     <= pix_next;
            group_reg   <= grp.group;
            row_end_reg <= grp.row_end;
        end
    end

    assign m_valid       = valid_reg;
    assign m_pix         = pix_reg;
    assign m_group_index = group_reg;
    assign m_row_end     = row_end_reg;

endmodule
